/* sv/wfs_pkg.sv */
// Shared types and constants for the wall-follow steering block.
// No dependencies; imported by every other file of the block.
package wfs_pkg;

	localparam int unsigned CFG_W     = 16;
	localparam int unsigned SPEED_W   = 14;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned ACTION_W  = 2;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_RIGHT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRONT_BLOCK   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ADVANCE       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_FLOOR  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED  = 3'd6;

	// reset values of the registers
	localparam logic [CFG_W-1:0]   RST_BAND_LOW     = 16'd100;
	localparam logic [CFG_W-1:0]   RST_BAND_HIGH    = 16'd140;
	localparam logic [CFG_W-1:0]   RST_OPEN_RIGHT   = 16'd200;
	localparam logic [CFG_W-1:0]   RST_FRONT_BLOCK  = 16'd70;
	localparam logic [CFG_W-1:0]   RST_ADVANCE      = 16'd100;
	localparam logic [CFG_W-1:0]   RST_TARGET_FLOOR = 16'd100;
	localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED = 14'd3500;

	typedef enum logic [1:0] {
		MODE_FOLLOW = 2'd0,
		MODE_LEFT   = 2'd1,
		MODE_RIGHT  = 2'd2
	} mode_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_STOP = 2'd0,
		ACT_FWD  = 2'd1,
		ACT_SPIN = 2'd2
	} action_t;

	typedef struct packed {
		logic [CFG_W-1:0]   band_low;
		logic [CFG_W-1:0]   band_high;
		logic [CFG_W-1:0]   open_right_limit;
		logic [CFG_W-1:0]   front_block_limit;
		logic [CFG_W-1:0]   advance_before_turn;
		logic [CFG_W-1:0]   target_floor;
		logic [SPEED_W-1:0] cruise_speed;
	} cfg_t;

	typedef struct packed {
		action_t            action;
		logic [SPEED_W-1:0] left_speed;
		logic [SPEED_W-1:0] right_speed;
	} cmd_t;

endpackage

/* sv/wfs_cfg_regs.sv */
// Configuration register file: seven write-only registers with reset values.
// Depends on wfs_pkg.
module wfs_cfg_regs import wfs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_low            <= RST_BAND_LOW;
			cfg_q.band_high           <= RST_BAND_HIGH;
			cfg_q.open_right_limit    <= RST_OPEN_RIGHT;
			cfg_q.front_block_limit   <= RST_FRONT_BLOCK;
			cfg_q.advance_before_turn <= RST_ADVANCE;
			cfg_q.target_floor        <= RST_TARGET_FLOOR;
			cfg_q.cruise_speed        <= RST_CRUISE_SPEED;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BAND_LOW:     cfg_q.band_low            <= cfg_data;
				REG_BAND_HIGH:    cfg_q.band_high           <= cfg_data;
				REG_OPEN_RIGHT:   cfg_q.open_right_limit    <= cfg_data;
				REG_FRONT_BLOCK:  cfg_q.front_block_limit   <= cfg_data;
				REG_ADVANCE:      cfg_q.advance_before_turn <= cfg_data;
				REG_TARGET_FLOOR: cfg_q.target_floor        <= cfg_data;
				REG_CRUISE_SPEED: cfg_q.cruise_speed        <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/wfs_ctrl.sv */
// Steering decision: mode state machine, turn state and the wheel command
// for one item. Depends on wfs_pkg.
module wfs_ctrl import wfs_pkg::*; #(
	parameter int unsigned DISTANCE_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [DISTANCE_WIDTH-1:0] right_mm,
	input  logic [DISTANCE_WIDTH-1:0] center_mm,
	input  cfg_t                      cfg,
	output cmd_t                      cmd
);

	// compare width: covers both the distances and the 16-bit limits
	localparam int unsigned CW = (DISTANCE_WIDTH > CFG_W) ? DISTANCE_WIDTH : CFG_W;

	mode_t                     mode_q, mode_d;
	logic                      stage_q, stage_d;
	logic [CW-1:0]             target_q, target_d;
	logic [DISTANCE_WIDTH-1:0] last_q, last_d;

	logic [CW-1:0] right_w, center_w, adv_w, floor_w, diff_w;
	logic [CW-1:0] target_eff;
	logic [DISTANCE_WIDTH-1:0] last_eff;
	logic go_left, go_right, stage_eff;
	logic [SPEED_W-1:0] fast, slow;

	assign right_w  = CW'(right_mm);
	assign center_w = CW'(center_mm);
	assign adv_w    = CW'(cfg.advance_before_turn);
	assign floor_w  = CW'(cfg.target_floor);
	assign diff_w   = center_w - adv_w;
	assign fast     = cfg.cruise_speed;
	assign slow     = cfg.cruise_speed >> 1;

	// mode selection and the values that turn entry loads
	always_comb begin
		go_left  = (mode_q == MODE_LEFT) ||
			((mode_q == MODE_FOLLOW) && (right_w > CW'(cfg.open_right_limit)));
		go_right = !go_left && ((mode_q == MODE_RIGHT) ||
			((mode_q == MODE_FOLLOW) && (center_w < CW'(cfg.front_block_limit))));
		target_eff = target_q;
		last_eff   = last_q;
		stage_eff  = stage_q;
		if (mode_q == MODE_FOLLOW && go_left) begin
			// no wrap: a short centre reading falls back to the floor
			if (center_w >= adv_w && diff_w >= floor_w)
				target_eff = diff_w;
			else
				target_eff = floor_w;
			stage_eff = 1'b0;
		end else if (mode_q == MODE_FOLLOW && go_right) begin
			last_eff  = right_mm;
			stage_eff = 1'b0;
		end
	end

	// next state
	always_comb begin
		mode_d   = mode_q;
		stage_d  = stage_q;
		target_d = target_q;
		last_d   = last_q;
		if (go_left) begin
			target_d = target_eff;
			stage_d  = stage_eff;
			mode_d   = MODE_LEFT;
			if (!stage_eff) begin
				if (center_w < target_eff)
					stage_d = 1'b1;
			end else if (right_w < CW'(cfg.band_high)) begin
				mode_d = MODE_FOLLOW;
			end
		end else if (go_right) begin
			last_d  = last_eff;
			stage_d = stage_eff;
			mode_d  = MODE_RIGHT;
			if (!stage_eff) begin
				if (right_mm > last_eff)
					stage_d = 1'b1;
				else
					last_d = right_mm;
			end else if (right_w >= CW'(cfg.band_low)) begin
				mode_d = MODE_FOLLOW;
			end
		end else begin
			mode_d = MODE_FOLLOW;
		end
	end

	// wheel command
	always_comb begin
		cmd = '{action: ACT_FWD, left_speed: fast, right_speed: fast};
		if (go_left) begin
			if (!stage_eff) begin
				if (center_w < target_eff)
					cmd = '{action: ACT_STOP, left_speed: '0, right_speed: '0};
			end else if (right_w < CW'(cfg.band_high)) begin
				cmd = '{action: ACT_STOP, left_speed: '0, right_speed: '0};
			end else begin
				cmd = '{action: ACT_FWD, left_speed: slow, right_speed: fast};
			end
		end else if (go_right) begin
			cmd = '{action: ACT_SPIN, left_speed: slow, right_speed: slow};
			if (!stage_eff) begin
				if (right_mm > last_eff)
					cmd = '{action: ACT_STOP, left_speed: '0, right_speed: '0};
			end else if (right_w >= CW'(cfg.band_low)) begin
				cmd = '{action: ACT_STOP, left_speed: '0, right_speed: '0};
			end
		end else if (right_w < CW'(cfg.band_low)) begin
			cmd = '{action: ACT_FWD, left_speed: fast, right_speed: slow};
		end else if (right_w > CW'(cfg.band_high)) begin
			cmd = '{action: ACT_FWD, left_speed: slow, right_speed: fast};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_FOLLOW;
			stage_q  <= 1'b0;
			target_q <= '0;
			last_q   <= '0;
		end else if (step) begin
			mode_q   <= mode_d;
			stage_q  <= stage_d;
			target_q <= target_d;
			last_q   <= last_d;
		end
	end

`ifndef NO_ASSERTIONS
	// a right spin always starts in its first stage
	a_entry_stage: assert property (@(posedge clk) disable iff (!arst_n)
		step && mode_q == MODE_FOLLOW && mode_d == MODE_RIGHT |=> !stage_q)
		else $error("spin entered with stage set");

	// leaving a turn only happens from its second stage, with a stop
	a_exit_stop: assert property (@(posedge clk) disable iff (!arst_n)
		step && mode_q != MODE_FOLLOW && mode_d == MODE_FOLLOW |->
		stage_q && cmd.action == ACT_STOP)
		else $error("turn left without stop from second stage");
`endif

endmodule

/* sv/wall_follow_steering_fsm.sv */
// Top level of the wall-follow steering block: input register, decision
// logic and output register. Depends on wfs_pkg, wfs_cfg_regs, wfs_ctrl.
// Result path: the input register, then the result register; an item waits
// in either register while the output is stalled.
// Throughput: one item per cycle unless the output stalls; the decision and
// the state update sit in one combinational pass between the two registers.
// Reset: arst_n clears pipeline valids, mode/turn state, and loads the
// register defaults; no clearing pass.
module wall_follow_steering_fsm import wfs_pkg::*; #(
	parameter int unsigned DISTANCE_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [DISTANCE_WIDTH-1:0] right_mm,
	input  logic [DISTANCE_WIDTH-1:0] center_mm,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ACTION_W-1:0]       drive_action,
	output logic [SPEED_W-1:0]        left_wheel_speed,
	output logic [SPEED_W-1:0]        right_wheel_speed,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data
);

	cfg_t cfg;
	cmd_t cmd;

	logic                      valid_s1;
	logic [DISTANCE_WIDTH-1:0] right_s1, center_s1;
	logic                      valid_s2;
	cmd_t                      cmd_s2;
	logic                      s2_take, step;

	assign s2_take  = !valid_s2 || out_ready;
	assign step     = valid_s1 && s2_take;
	assign in_ready = !valid_s1 || s2_take;

	wfs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wfs_ctrl #(
		.DISTANCE_WIDTH (DISTANCE_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.right_mm  (right_s1),
		.center_mm (center_s1),
		.cfg       (cfg),
		.cmd       (cmd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			right_s1  <= right_mm;
			center_s1 <= center_mm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_take) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			cmd_s2 <= cmd;
	end

	assign out_valid         = valid_s2;
	assign drive_action      = cmd_s2.action;
	assign left_wheel_speed  = cmd_s2.left_speed;
	assign right_wheel_speed = cmd_s2.right_speed;

`ifndef NO_ASSERTIONS
	// an item in the input register is never dropped while the output stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_take |=> valid_s1 && $stable(right_s1) && $stable(center_s1))
		else $error("input register item lost under stall");

	// every decision step lands in the result register
	a_step_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("decision step produced no result");

	// a stop command carries zero wheel speeds
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && cmd_s2.action == ACT_STOP |->
		cmd_s2.left_speed == '0 && cmd_s2.right_speed == '0)
		else $error("stop with nonzero wheel speed");
`endif

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for wall_follow_steering_fsm: directed and random samples
// under several register settings, with a built-in steering predictor.
// Depends on wfs_pkg and the wall_follow_steering_fsm RTL.
module tb_top;
	import wfs_pkg::*;

	localparam int DW = 16;
	localparam int DIST_MAX = (1 << DW) - 1;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [DW-1:0] right_mm;
		logic [DW-1:0] center_mm;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [DW-1:0] right_mm = '0;
	logic [DW-1:0] center_mm = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ACTION_W-1:0] drive_action;
	logic [SPEED_W-1:0] left_wheel_speed;
	logic [SPEED_W-1:0] right_wheel_speed;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	wall_follow_steering_fsm #(.DISTANCE_WIDTH(DW)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.right_mm(right_mm),
		.center_mm(center_mm),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_action(drive_action),
		.left_wheel_speed(left_wheel_speed),
		.right_wheel_speed(right_wheel_speed),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// register shadow and steering state of the predictor
	cfg_t regs = {RST_BAND_LOW, RST_BAND_HIGH, RST_OPEN_RIGHT, RST_FRONT_BLOCK,
		RST_ADVANCE, RST_TARGET_FLOOR, RST_CRUISE_SPEED};
	mode_t mode_q = MODE_FOLLOW;
	logic stage_q = 1'b0;
	logic [DW-1:0] target_q = '0;
	logic [DW-1:0] last_right_q = '0;

	sample_t samples_to_send[$];
	cmd_t expected_cmds[$];
	sample_t next_sample;
	cmd_t want;
	int queued = 0;
	int mismatches = 0;
	int results_seen = 0;

	function automatic cmd_t steer_predict(input logic [DW-1:0] r, input logic [DW-1:0] c);
		logic [SPEED_W-1:0] fast;
		logic [SPEED_W-1:0] slow;
		logic [DW-1:0] ahead;
		cmd_t cmd;
		fast = regs.cruise_speed;
		slow = regs.cruise_speed >> 1;
		cmd = '{ACT_STOP, '0, '0};
		if ((mode_q == MODE_FOLLOW && r > regs.open_right_limit) || mode_q == MODE_LEFT) begin
			if (mode_q == MODE_FOLLOW) begin
				// target is clamped to the floor; center below the advance never wraps
				target_q = regs.target_floor;
				if (c >= regs.advance_before_turn) begin
					ahead = c - regs.advance_before_turn;
					if (ahead >= regs.target_floor)
						target_q = ahead;
				end
				stage_q = 1'b0;
			end
			mode_q = MODE_LEFT;
			if (!stage_q) begin
				if (c < target_q)
					stage_q = 1'b1;
				else
					cmd = '{ACT_FWD, fast, fast};
			end else if (r < regs.band_high) begin
				mode_q = MODE_FOLLOW;
			end else begin
				cmd = '{ACT_FWD, slow, fast};
			end
		end else if ((mode_q == MODE_FOLLOW && c < regs.front_block_limit) ||
				mode_q == MODE_RIGHT) begin
			if (mode_q == MODE_FOLLOW) begin
				last_right_q = r;
				stage_q = 1'b0;
			end
			mode_q = MODE_RIGHT;
			if (!stage_q) begin
				if (r > last_right_q) begin
					stage_q = 1'b1;
				end else begin
					last_right_q = r;
					cmd = '{ACT_SPIN, slow, slow};
				end
			end else if (r >= regs.band_low) begin
				mode_q = MODE_FOLLOW;
			end else begin
				cmd = '{ACT_SPIN, slow, slow};
			end
		end else begin
			mode_q = MODE_FOLLOW;
			if (r < regs.band_low)
				cmd = '{ACT_FWD, fast, slow};
			else if (r > regs.band_high)
				cmd = '{ACT_FWD, slow, fast};
			else
				cmd = '{ACT_FWD, fast, fast};
		end
		return cmd;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("ERROR: %s: got %0d, expected %0d (result %0d, t=%0t)",
			what, got, exp_val, results_seen, $realtime);
		mismatches++;
	endtask

	// ---------------- stimulus helpers ----------------

	function automatic logic [DW-1:0] clip(input int v);
		if (v < 0)
			return '0;
		if (v > DIST_MAX)
			return DIST_MAX[DW-1:0];
		return v[DW-1:0];
	endfunction

	function automatic int pick_around(input int mid, input int spread);
		return mid - spread + int'($urandom_range(0, 2 * spread));
	endfunction

	task automatic push_sample(input int r, input int c);
		sample_t s;
		s.right_mm = clip(r);
		s.center_mm = clip(c);
		samples_to_send.push_back(s);
		queued++;
	endtask

	task automatic queue_noise();
		repeat ($urandom_range(1, 3))
			push_sample($urandom_range(0, DIST_MAX), $urandom_range(0, DIST_MAX));
	endtask

	task automatic queue_follow();
		int bl;
		int bh;
		bl = int'(regs.band_low);
		bh = int'(regs.band_high);
		repeat ($urandom_range(1, 8))
			push_sample(pick_around((bl + bh) / 2, (bh - bl) / 2 + 30),
				int'(regs.front_block_limit) + int'($urandom_range(0, 600)));
	endtask

	// entry, a few stage-0 items, the stop, stage-1 items, the exit
	task automatic queue_left_turn();
		int adv;
		int flr;
		int bh;
		int c0;
		int t;
		adv = int'(regs.advance_before_turn);
		flr = int'(regs.target_floor);
		bh = int'(regs.band_high);
		c0 = int'(clip(adv + flr + int'($urandom_range(0, 400))));
		if (c0 < 1)
			c0 = 1;
		t = flr;
		if (c0 >= adv && c0 - adv >= flr)
			t = c0 - adv;
		push_sample(int'(regs.open_right_limit) + int'($urandom_range(1, 400)), c0);
		repeat ($urandom_range(0, 4))
			push_sample($urandom_range(0, DIST_MAX), t + int'($urandom_range(0, 60)));
		if (t > 0)
			push_sample($urandom_range(0, DIST_MAX),
				t - 1 - int'($urandom_range(0, (t - 1 < 30) ? t - 1 : 30)));
		repeat ($urandom_range(0, 4))
			push_sample(bh + int'($urandom_range(0, 80)), $urandom_range(0, DIST_MAX));
		if (bh > 0)
			push_sample(bh - 1 - int'($urandom_range(0, (bh - 1 < 30) ? bh - 1 : 30)),
				$urandom_range(0, DIST_MAX));
	endtask

	// entry, right distance falling, the rise that stops the spin, then the exit
	task automatic queue_right_spin();
		int fr;
		int bl;
		int r;
		fr = int'(regs.front_block_limit);
		bl = int'(regs.band_low);
		if (fr == 0) begin
			queue_noise();
		end else begin
			r = int'(clip(pick_around(bl, 60)));
			if (r > DIST_MAX - 1)
				r = DIST_MAX - 1;
			push_sample(r, $urandom_range(0, fr - 1));
			repeat ($urandom_range(0, 4)) begin
				r = r - int'($urandom_range(0, 8));
				if (r < 0)
					r = 0;
				push_sample(r, $urandom_range(0, DIST_MAX));
			end
			push_sample(r + 1 + int'($urandom_range(0, 30)), $urandom_range(0, DIST_MAX));
			if (bl > 0)
				repeat ($urandom_range(0, 3))
					push_sample($urandom_range(0, bl - 1), $urandom_range(0, DIST_MAX));
			push_sample(bl + int'($urandom_range(0, 40)), $urandom_range(0, DIST_MAX));
		end
	endtask

	task automatic queue_random_items(input int count);
		int pick;
		queued = 0;
		while (queued < count) begin
			pick = $urandom_range(0, 9);
			if (pick < 2)
				queue_noise();
			else if (pick < 5)
				queue_follow();
			else if (pick < 8)
				queue_left_turn();
			else
				queue_right_spin();
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_BAND_LOW: regs.band_low = data;
			REG_BAND_HIGH: regs.band_high = data;
			REG_OPEN_RIGHT: regs.open_right_limit = data;
			REG_FRONT_BLOCK: regs.front_block_limit = data;
			REG_ADVANCE: regs.advance_before_turn = data;
			REG_TARGET_FLOOR: regs.target_floor = data;
			REG_CRUISE_SPEED: regs.cruise_speed = data[SPEED_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_regs(input int bl, input int bh, input int open_lim, input int front,
			input int adv, input int flr, input int speed);
		write_reg(REG_BAND_LOW, CFG_W'(bl));
		write_reg(REG_BAND_HIGH, CFG_W'(bh));
		write_reg(REG_OPEN_RIGHT, CFG_W'(open_lim));
		write_reg(REG_FRONT_BLOCK, CFG_W'(front));
		write_reg(REG_ADVANCE, CFG_W'(adv));
		write_reg(REG_TARGET_FLOOR, CFG_W'(flr));
		write_reg(REG_CRUISE_SPEED, CFG_W'(speed));
		// index past the register list must be ignored
		write_reg(REG_UNUSED, CFG_W'($urandom_range(0, DIST_MAX)));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_random_regs();
		int bl;
		int bh;
		bl = $urandom_range(20, 400);
		bh = bl + int'($urandom_range(0, 200));
		load_regs(bl, bh, bh + int'($urandom_range(1, 300)), $urandom_range(0, 300),
			$urandom_range(0, 300), $urandom_range(1, 300), $urandom_range(0, 16383));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (samples_to_send.size() != 0 || in_valid || expected_cmds.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ---------------- sender ----------------

	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_cmds.push_back(steer_predict(right_mm, center_mm));
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (samples_to_send.size() != 0) begin
					next_sample = samples_to_send.pop_front();
					right_mm <= next_sample.right_mm;
					center_mm <= next_sample.center_mm;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 16);
						gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- receiver and checker ----------------

	int ready_style = 0;
	int style_left = 0;
	int hold_left = 0;
	int holds_done = 0;
	int hold_at = 60;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (expected_cmds.size() == 0) begin
					report_mismatch("result with nothing expected, action",
						int'(drive_action), 0);
				end else begin
					want = expected_cmds.pop_front();
					if (drive_action !== want.action)
						report_mismatch("drive_action", int'(drive_action),
							int'(want.action));
					if (left_wheel_speed !== want.left_speed)
						report_mismatch("left_wheel_speed", int'(left_wheel_speed),
							int'(want.left_speed));
					if (right_wheel_speed !== want.right_speed)
						report_mismatch("right_wheel_speed", int'(right_wheel_speed),
							int'(want.right_speed));
				end
			end

			if (style_left == 0) begin
				ready_style <= $urandom_range(0, 2);
				style_left <= $urandom_range(8, 64);
			end else begin
				style_left <= style_left - 1;
			end

			// long hold-off while the sender has plenty queued, so the block backs up
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (holds_done < 2 && results_seen >= hold_at &&
					samples_to_send.size() > 40) begin
				hold_left <= HOLD_CYCLES;
				holds_done <= holds_done + 1;
				hold_at <= results_seen + 300;
				out_ready <= 1'b0;
			end else begin
				case (ready_style)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ---------------- watchdog ----------------

	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------- sequence of phases ----------------

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset register values
		push_sample(120, 500);
		push_sample(0, DIST_MAX);
		push_sample(100, 70);          // band low edge, front exactly at limit
		push_sample(140, 1000);        // band high edge
		push_sample(200, 1000);        // right at the open limit, no turn yet
		push_sample(DIST_MAX, DIST_MAX);
		push_sample(DIST_MAX, DIST_MAX - 100);  // center equal to target keeps going
		push_sample(300, 0);
		push_sample(DIST_MAX, 0);
		push_sample(140, 5);
		push_sample(139, 5);
		push_sample(250, 50);          // open right and blocked front: left wins, floor target
		push_sample(0, 0);
		push_sample(120, 69);          // spin entry
		push_sample(120, 0);           // equal right does not end the spin
		push_sample(37, DIST_MAX);
		push_sample(38, 0);
		push_sample(99, 0);
		push_sample(100, 0);
		push_sample(150, 100);
		push_sample(201, 199);         // center minus advance below floor
		push_sample(DIST_MAX, 99);
		push_sample(0, DIST_MAX);
		push_sample(201, 200);         // center minus advance equal to floor
		push_sample(139, 99);
		wait_idle();

		repeat (4) begin
			load_random_regs();
			queue_random_items(120);
			wait_idle();
		end

		load_regs(0, 1, 0, 0, 0, 0, 0);
		queue_random_items(70);
		wait_idle();

		// all ones; cruise speed data above the 14-bit range
		load_regs(DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX);
		queue_random_items(70);
		wait_idle();

		load_random_regs();
		queue_random_items(80);
		wait_idle();

		// a left turn can never finish with a zero band; kept for the end
		load_regs(0, 0, 0, 0, 0, 0, 0);
		queue_random_items(40);
		wait_idle();

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
